[hw/rtl/vsd_pkg.sv]
// ----------------------------------------------------------------------------
// vsd_pkg
// shared constants and types of the segment deframer
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int PACKET_BYTES         = 164;
    localparam int LOOKAHEAD_PACKETS    = 20;
    localparam int SEGMENTS             = 4;
    localparam int SEGMENT_ROWS         = 60;
    localparam int MAX_TRANSFER_PACKETS = 720;

    localparam int RING_PACKETS = LOOKAHEAD_PACKETS + 1;
    localparam int RING_BYTES   = RING_PACKETS * PACKET_BYTES;
    localparam int ROW_PIXELS   = (PACKET_BYTES - 4) / 2;
    localparam int FRAME_ROWS   = SEGMENTS * SEGMENT_ROWS;
    localparam int STORE_PIXELS = FRAME_ROWS * ROW_PIXELS;
    localparam int PAYLOAD_BYTES = PACKET_BYTES - 4;

    localparam int RING_AW  = $clog2(RING_BYTES);
    localparam int STORE_AW = $clog2(STORE_PIXELS);
    localparam int OFF_W    = $clog2(PACKET_BYTES);
    localparam int SLOT_W   = $clog2(RING_PACKETS + LOOKAHEAD_PACKETS);
    localparam int PKT_W    = 10;
    localparam int CNT_W    = $clog2(PAYLOAD_BYTES);

    localparam logic       CMD_PUSH   = 1'b0;
    localparam logic       CMD_READ   = 1'b1;
    localparam logic [3:0] ID_DISCARD = 4'hf;

    typedef struct packed {
        logic                is_read;
        logic [7:0]          data_byte;
        logic                rd_ok;
        logic [STORE_AW-1:0] rd_addr;
    } q_item_t;

endpackage

[hw/rtl/vospi_segment_deframer.sv]
// ----------------------------------------------------------------------------
// vospi_segment_deframer
// deframes a VoSPI byte stream into a segmented frame store
// ----------------------------------------------------------------------------
// A push that does not end a packet writes its byte to the packet ring, and its
// result is valid in the cycle after it leaves the input queue; a read passes
// through the frame-store read register and S_READ first. The push that ends a
// packet resolves at most one packet (the one twenty packets back),
// and the push that ends a transfer resolves every packet left, up to 21.
// Resolving one packet reads header bytes on the single read port of the
// packet ring, and a packet that is copied goes one payload byte per cycle
// into the frame store. A two-entry queue keeps taking transactions, until it
// is full, while the back end resolves or a result waits on m_tready.
module vospi_segment_deframer import vsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,   // transfer_packets
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // data_byte, read_row, read_column, pad
    input  logic        s_tuser,       // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata        // pixel_value, segment_mask, transfer_done, pad
);

    logic [PKT_W-1:0] tp_reg;
    logic [PKT_W-1:0] limit;
    logic             q_full, q_push, q_pop, q_valid;
    q_item_t          q_in, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            tp_reg <= PKT_W'(MAX_TRANSFER_PACKETS);
        else if (cfg_wr_en)
            tp_reg <= cfg_wr_data;
    end

    assign limit = (tp_reg == '0) ? PKT_W'(1)
                 : (32'(tp_reg) > MAX_TRANSFER_PACKETS) ? PKT_W'(MAX_TRANSFER_PACKETS)
                 : tp_reg;

    vsd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    vsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    vsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .limit    (limit),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hw/rtl/vsd_front.sv]
// ----------------------------------------------------------------------------
// vsd_front
// accepts input transactions and classifies them for the back end
// ----------------------------------------------------------------------------
module vsd_front import vsd_pkg::*; (
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        q_full,
    output logic        q_push,
    output q_item_t     q_item
);

    logic [7:0] row;
    logic [6:0] col;

    assign row      = s_tdata[15:8];
    assign col      = s_tdata[22:16];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.is_read   = (s_tuser == CMD_READ);
        q_item.data_byte = s_tdata[7:0];
        q_item.rd_ok     = (32'(row) < FRAME_ROWS) && (32'(col) < ROW_PIXELS);
        q_item.rd_addr   = STORE_AW'(32'(row) * ROW_PIXELS + 32'(col));
    end

endmodule

[hw/rtl/vsd_queue.sv]
// ----------------------------------------------------------------------------
// vsd_queue
// two-entry queue between the front and back ends
// ----------------------------------------------------------------------------
module vsd_queue import vsd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  q_item_t push_item,
    output logic    full,
    input  logic    pop,
    output logic    valid,
    output q_item_t head
);

    q_item_t    mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[hw/rtl/vsd_back.sv]
// ----------------------------------------------------------------------------
// vsd_back
// packet ring, packet resolver, frame store and result register
// ----------------------------------------------------------------------------
module vsd_back import vsd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [PKT_W-1:0] limit,
    input  logic             q_valid,
    input  q_item_t          q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CHECK, S_ID, S_NUM, S_HDR, S_LA0, S_LA1,
        S_ROW, S_COPY, S_DRAIN, S_NEXT
    } state_t;

    state_t state_reg;

    logic [7:0]           ring_mem [RING_BYTES];
    logic [15:0]          fs_mem   [STORE_PIXELS];
    logic [7:0]           ring_rd_reg;
    logic [15:0]          fs_rd_reg;
    logic [RING_AW-1:0]   ring_ra;
    logic                 ring_we;
    logic [RING_AW-1:0]   ring_wa;
    logic                 fs_we;
    logic [STORE_AW-1:0]  fs_wa;

    logic [OFF_W-1:0]     off_reg;
    logic [PKT_W-1:0]     pkt_reg;
    logic [SLOT_W-1:0]    wslot_reg;
    logic [RING_AW-1:0]   wbase_reg;
    logic [PKT_W-1:0]     rpos_reg;
    logic [SLOT_W-1:0]    rslot_reg;
    logic [RING_AW-1:0]   rbase_reg;
    logic                 sync_reg;
    logic [2:0]           seg_reg;
    logic [3:0]           mask_reg;
    logic                 has_la_reg;
    logic [7:0]           num_reg;
    logic [2:0]           la_seg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 pv_reg;
    logic                 plo_reg;
    logic [7:0]           hi_reg;
    logic [STORE_AW-1:0]  row_base_reg;
    logic [STORE_AW-1:0]  pix_reg;
    logic                 rd_ok_reg;
    logic                 m_valid_reg;
    logic [15:0]          m_pixel_reg;
    logic                 m_done_reg;

    logic [SLOT_W-1:0]    la_slot_sum, la_slot;
    logic [RING_AW-1:0]   la_base;
    logic                 sync_eff;
    logic                 take;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, m_done_reg, mask_reg, m_pixel_reg};
    assign take     = (state_reg == S_IDLE) && q_valid && !m_valid_reg;
    assign q_pop    = take;

    assign la_slot_sum = rslot_reg + SLOT_W'(LOOKAHEAD_PACKETS);
    assign la_slot     = (32'(la_slot_sum) >= RING_PACKETS)
                         ? la_slot_sum - SLOT_W'(RING_PACKETS) : la_slot_sum;
    assign la_base     = RING_AW'(32'(la_slot) * PACKET_BYTES);
    assign sync_eff    = sync_reg && (ring_rd_reg != 8'd0);

    always_comb begin
        ring_ra = rbase_reg;
        unique case (state_reg)
            S_NUM:   ring_ra = rbase_reg + RING_AW'(1);
            S_HDR:   ring_ra = la_base;
            S_LA0:   ring_ra = la_base + RING_AW'(1);
            S_COPY:  ring_ra = rbase_reg + RING_AW'(cnt_reg) + RING_AW'(4);
            default: ring_ra = rbase_reg;
        endcase
    end

    assign ring_we = take && !q_head.is_read;
    assign ring_wa = wbase_reg + RING_AW'(off_reg);
    assign fs_we   = pv_reg && plo_reg;
    assign fs_wa   = row_base_reg + pix_reg;

    always_ff @(posedge aclk) begin
        if (ring_we)
            ring_mem[ring_wa] <= q_head.data_byte;
        ring_rd_reg <= ring_mem[ring_ra];
    end

    always_ff @(posedge aclk) begin
        if (fs_we)
            fs_mem[fs_wa] <= {hi_reg, ring_rd_reg};
        fs_rd_reg <= fs_mem[q_head.rd_addr];
    end

    // payload byte pairing, in the cycle after the ring read
    always_ff @(posedge aclk) begin
        pv_reg  <= (state_reg == S_COPY);
        plo_reg <= cnt_reg[0];
        if (pv_reg && !plo_reg)
            hi_reg <= ring_rd_reg;
        if (state_reg == S_ROW)
            pix_reg <= '0;
        else if (fs_we)
            pix_reg <= pix_reg + STORE_AW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            off_reg     <= '0;
            pkt_reg     <= '0;
            wslot_reg   <= '0;
            wbase_reg   <= '0;
            rpos_reg    <= '0;
            rslot_reg   <= '0;
            rbase_reg   <= '0;
            sync_reg    <= 1'b0;
            seg_reg     <= '0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
            has_la_reg  <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        if (q_head.is_read) begin
                            rd_ok_reg <= q_head.rd_ok;
                            state_reg <= S_READ;
                        end else if (32'(off_reg) == PACKET_BYTES - 1) begin
                            off_reg <= '0;
                            pkt_reg <= pkt_reg + PKT_W'(1);
                            if (32'(wslot_reg) == RING_PACKETS - 1) begin
                                wslot_reg <= '0;
                                wbase_reg <= '0;
                            end else begin
                                wslot_reg <= wslot_reg + SLOT_W'(1);
                                wbase_reg <= wbase_reg + RING_AW'(PACKET_BYTES);
                            end
                            state_reg <= S_CHECK;
                        end else begin
                            off_reg     <= off_reg + OFF_W'(1);
                            m_valid_reg <= 1'b1;
                            m_pixel_reg <= '0;
                            m_done_reg  <= 1'b0;
                        end
                    end
                end
                S_READ: begin
                    m_valid_reg <= 1'b1;
                    m_pixel_reg <= rd_ok_reg ? fs_rd_reg : 16'd0;
                    m_done_reg  <= 1'b0;
                    state_reg   <= S_IDLE;
                end
                S_CHECK: begin
                    if (11'(rpos_reg) + 11'(LOOKAHEAD_PACKETS) < 11'(pkt_reg)) begin
                        has_la_reg <= 1'b1;
                        state_reg  <= S_ID;
                    end else if (pkt_reg >= limit && rpos_reg < pkt_reg) begin
                        has_la_reg <= 1'b0;
                        state_reg  <= S_ID;
                    end else begin
                        if (pkt_reg >= limit) begin
                            pkt_reg   <= '0;
                            wslot_reg <= '0;
                            wbase_reg <= '0;
                            rpos_reg  <= '0;
                            rslot_reg <= '0;
                            rbase_reg <= '0;
                            sync_reg  <= 1'b0;
                            seg_reg   <= '0;
                        end
                        m_valid_reg <= 1'b1;
                        m_pixel_reg <= '0;
                        m_done_reg  <= (pkt_reg >= limit);
                        state_reg   <= S_IDLE;
                    end
                end
                S_ID: state_reg <= S_NUM;
                S_NUM: begin
                    if (ring_rd_reg[3:0] == ID_DISCARD) begin
                        sync_reg  <= 1'b0;
                        state_reg <= S_NEXT;
                    end else begin
                        state_reg <= S_HDR;
                    end
                end
                S_HDR: begin
                    num_reg  <= ring_rd_reg;
                    sync_reg <= sync_eff;
                    if (ring_rd_reg != 8'd0 && !sync_reg)
                        state_reg <= S_NEXT;
                    else if (!sync_eff && has_la_reg)
                        state_reg <= S_LA0;
                    else
                        state_reg <= S_ROW;
                end
                S_LA0: begin
                    la_seg_reg <= ring_rd_reg[6:4];
                    state_reg  <= S_LA1;
                end
                S_LA1: begin
                    if (la_seg_reg != 3'd0 && 32'(la_seg_reg) <= SEGMENTS
                        && 32'(ring_rd_reg) == LOOKAHEAD_PACKETS) begin
                        sync_reg <= 1'b1;
                        seg_reg  <= la_seg_reg;
                    end
                    state_reg <= S_ROW;
                end
                S_ROW: begin
                    if (!sync_reg || 32'(num_reg) > SEGMENT_ROWS - 1) begin
                        state_reg <= S_NEXT;
                    end else begin
                        row_base_reg <= STORE_AW'(32'(seg_reg - 3'd1)
                                        * (SEGMENT_ROWS * ROW_PIXELS)
                                        + 32'(num_reg) * ROW_PIXELS);
                        cnt_reg   <= '0;
                        state_reg <= S_COPY;
                    end
                end
                S_COPY: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (32'(cnt_reg) == PAYLOAD_BYTES - 1)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (32'(num_reg) == SEGMENT_ROWS - 1)
                        mask_reg <= mask_reg | (4'd1 << (seg_reg - 3'd1));
                    state_reg <= S_NEXT;
                end
                S_NEXT: begin
                    rpos_reg <= rpos_reg + PKT_W'(1);
                    if (32'(rslot_reg) == RING_PACKETS - 1) begin
                        rslot_reg <= '0;
                        rbase_reg <= '0;
                    end else begin
                        rslot_reg <= rslot_reg + SLOT_W'(1);
                        rbase_reg <= rbase_reg + RING_AW'(PACKET_BYTES);
                    end
                    state_reg <= S_CHECK;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/vsd_checker.sv]
// ----------------------------------------------------------------------------
// vsd_checker
// port-level checks of the segment deframer
// ----------------------------------------------------------------------------
module vsd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_done_zero_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20] |-> m_tdata[15:0] == 16'd0)
        else $error("transfer end with nonzero pixel");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled transaction changed");

    a_mask_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && $past(m_tvalid) && $past(aresetn)
        |-> (m_tdata[19:16] & $past(m_tdata[19:16])) == $past(m_tdata[19:16]))
        else $error("segment bit cleared");

endmodule

bind vospi_segment_deframer vsd_checker u_vsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
